[design/stbs_pkg.sv]
// Shared types, codes and widths for the sorted table binary search block.
package stbs_pkg;

    localparam int KEY_W            = 27;
    localparam int PAY_W            = 32;
    localparam int REQ_W            = 2;
    localparam int STATUS_W         = 3;
    localparam int DEF_TABLE_DEPTH  = 512;

    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    req_ready;
        logic    load_req;
        logic    do_append;
        logic    do_clear;
        logic    init_search;
        logic    read_probe;
        logic    step_search;
        logic    set_res;
        t_status res_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_append;
        logic is_clear;
        logic full;
        logic empty;
        logic key_eq;
        logic more_left;
        logic out_free;
    } t_sts;

endpackage

[design/sorted_table_binary_search.sv]
// Sorted key/payload table with append, clear and binary-search lookup.
//
// Request channel: i_req_valid / o_req_stall carry req_type, search_key and
// payload_in. A request is taken on a clock edge with valid high and stall low.
// Query (type 0, also type 3) looks the key up over the filled entries;
// append (type 1) stores the next entry at the end, or answers table full;
// clear (type 2) empties the table. Every request yields one result.
// Result channel: o_res_valid / i_res_stall carry status and payload_out,
// which is the matching payload when found and zero otherwise.
// Flow: append, clear and a query of an empty table go from decode straight
// to the result register and then the output register. A query first runs P
// probes, where P is at most floor(log2(entries)) + 1; each probe is one
// synchronous table read and one key compare. One request is in work at a
// time; the next one is accepted the cycle after the previous result enters
// the output register.
// Reset empties the table and drops any pending result. While the receiver
// stalls the result holds, and a finished request waits in the controller.
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [KEY_W-1:0]    i_search_key,
    input  logic [PAY_W-1:0]    i_payload_in,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [PAY_W-1:0]    o_payload_out
);

    t_cmd cmd;
    t_sts sts;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_search_key  (i_search_key),
        .i_payload_in  (i_payload_in),
        .i_res_stall   (i_res_stall),
        .o_sts         (sts),
        .o_res_valid   (o_res_valid),
        .o_status      (o_status),
        .o_payload_out (o_payload_out)
    );

    assign o_req_stall = !cmd.req_ready;

endmodule

[design/stbs_ctrl.sv]
// Controller state machine: sequences decode, probe reads and result hand-off.
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_append || i_sts.is_clear || i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (!i_sts.key_eq && i_sts.more_left) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.res_code  = ST_NOT_FOUND;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.req_ready = 1'b1;
                o_cmd.load_req  = i_req_valid;
            end
            S_DECODE: begin
                if (i_sts.is_append) begin
                    o_cmd.do_append = 1'b1;
                    o_cmd.set_res   = 1'b1;
                    o_cmd.res_code  = i_sts.full ? ST_FULL : ST_APPENDED;
                end else if (i_sts.is_clear) begin
                    o_cmd.do_clear = 1'b1;
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_CLEARED;
                end else if (i_sts.empty) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_EMPTY;
                end else begin
                    o_cmd.init_search = 1'b1;
                end
            end
            S_READ: o_cmd.read_probe = 1'b1;
            S_CMP: begin
                if (i_sts.key_eq) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_FOUND;
                end else begin
                    // narrow the range; give up once it is empty
                    o_cmd.step_search = 1'b1;
                    if (!i_sts.more_left) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_NOT_FOUND;
                    end
                end
            end
            S_DONE: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[design/stbs_dp.sv]
// Datapath: table memories, entry count, search bounds and output register.
module stbs_dp
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [KEY_W-1:0]    i_search_key,
    input  logic [PAY_W-1:0]    i_payload_in,
    input  logic                i_res_stall,
    output t_sts                o_sts,
    output logic                o_res_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [PAY_W-1:0]    o_payload_out
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic [KEY_W-1:0] mem_key [TABLE_DEPTH];
    logic [PAY_W-1:0] mem_pay [TABLE_DEPTH];

    logic [REQ_W-1:0]    r_req;
    logic [KEY_W-1:0]    r_key;
    logic [PAY_W-1:0]    r_pay;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi_p1;
    logic [CNT_W-1:0]    r_mid;
    logic [KEY_W-1:0]    r_rd_key;
    logic [PAY_W-1:0]    r_rd_pay;
    t_status             r_res_status;
    logic [PAY_W-1:0]    r_res_payload;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [PAY_W-1:0]    r_out_payload;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_c;
    logic [CNT_W-1:0] mid_p1;
    logic             key_gt;
    logic             is_append;
    logic             is_clear;

    // midpoint of the closed range lo .. hi_p1 - 1
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi_p1} - {{CNT_W{1'b0}}, 1'b1};
    assign mid_c   = mid_sum[CNT_W:1];
    assign mid_p1  = r_mid + CNT_W'(1);
    assign key_gt  = r_rd_key > r_key;

    always_comb begin
        unique case (r_req)
            REQ_APPEND: begin
                is_append = 1'b1;
                is_clear  = 1'b0;
            end
            REQ_CLEAR: begin
                is_append = 1'b0;
                is_clear  = 1'b1;
            end
            default: begin
                is_append = 1'b0;
                is_clear  = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_sts.is_append = is_append;
        o_sts.is_clear  = is_clear;
        o_sts.full      = r_count == DEPTH_C;
        o_sts.empty     = r_count == '0;
        o_sts.key_eq    = r_rd_key == r_key;
        o_sts.more_left = key_gt ? (r_lo < r_mid) : (mid_p1 < r_hi_p1);
        o_sts.out_free  = !r_out_valid || !i_res_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_key <= i_search_key;
            r_pay <= i_payload_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_append && !o_sts.full) begin
            mem_key[r_count[IDX_W-1:0]] <= r_key;
            mem_pay[r_count[IDX_W-1:0]] <= r_pay;
        end
        if (i_cmd.read_probe) begin
            r_rd_key <= mem_key[mid_c[IDX_W-1:0]];
            r_rd_pay <= mem_pay[mid_c[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.do_clear) begin
            r_count <= '0;
        end else if (i_cmd.do_append && !o_sts.full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_search) begin
            r_lo    <= '0;
            r_hi_p1 <= r_count;
        end else if (i_cmd.step_search) begin
            if (key_gt) begin
                r_hi_p1 <= r_mid;
            end else begin
                r_lo <= mid_p1;
            end
        end
        if (i_cmd.read_probe) begin
            r_mid <= mid_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_status  <= i_cmd.res_code;
            r_res_payload <= (i_cmd.res_code == ST_FOUND) ? r_rd_pay : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= r_res_status;
            r_out_payload <= r_res_payload;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_payload_out = r_out_payload;

endmodule

[test/sorted_table_binary_search_tb.sv]
// Self-checking testbench for the sorted table binary search block.
module sorted_table_binary_search_tb;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_TOP = 27'd99999999;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_status          status;
        logic [PAY_W-1:0] payload;
    } t_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_req_valid;
    logic                o_req_stall;
    logic [REQ_W-1:0]    i_req_type;
    logic [KEY_W-1:0]    i_search_key;
    logic [PAY_W-1:0]    i_payload_in;
    logic                o_res_valid;
    logic                i_res_stall;
    logic [STATUS_W-1:0] o_status;
    logic [PAY_W-1:0]    o_payload_out;

    // Shadow copy of the table contents
    logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
    logic [PAY_W-1:0] table_pays [TABLE_DEPTH];
    int               table_count;

    t_result pending_results[$];
    t_result oldest;
    int      mismatches;
    int      send_idle_pct;
    int      res_stall_pct;
    int      quiet_cycles;

    sorted_table_binary_search #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_req_type    (i_req_type),
        .i_search_key  (i_search_key),
        .i_payload_in  (i_payload_in),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_status      (o_status),
        .o_payload_out (o_payload_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Apply one request to the shadow table and return the answer it earns.
    function automatic t_result table_response(logic [REQ_W-1:0] rt, logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] pay);
        t_result r;
        int lo;
        int hi;
        int mid;
        r.payload = '0;
        r.status  = ST_NOT_FOUND;
        if (rt == REQ_APPEND) begin
            if (table_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                table_keys[table_count] = key;
                table_pays[table_count] = pay;
                table_count++;
                r.status = ST_APPENDED;
            end
        end else if (rt == REQ_CLEAR) begin
            table_count = 0;
            r.status = ST_CLEARED;
        end else if (table_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            lo = 0;
            hi = table_count - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (table_keys[mid] > key) begin
                    hi = mid - 1;
                end else if (table_keys[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    r.status  = ST_FOUND;
                    r.payload = table_pays[mid];
                    break;
                end
            end
        end
        return r;
    endfunction

    // Drive one request, hold it until taken, then record its expected answer.
    task automatic send_request(input logic [REQ_W-1:0] rt, input logic [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid  <= 1'b1;
        i_req_type   <= rt;
        i_search_key <= key;
        i_payload_in <= pay;
        do @(posedge i_clk); while (o_req_stall);
        pending_results.push_back(table_response(rt, key, pay));
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        res_stall_pct = stall_pct;
    endtask

    task automatic test_directed_cases();
        send_request(REQ_QUERY, 27'd5, 32'h0);
        send_request(REQ_RESERVED, 27'd5, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 27'd0, 32'h0);
        send_request(REQ_APPEND, 27'd1000, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 27'd1000, 32'hA5A5_A5A5);
        send_request(REQ_APPEND, 27'd5000, 32'h1);
        send_request(REQ_APPEND, 27'h7FF_FFFF, 32'h5A5A_5A5A);
        send_request(REQ_QUERY, 27'd0, 32'h0);
        send_request(REQ_QUERY, 27'h7FF_FFFF, 32'h0);
        send_request(REQ_QUERY, 27'd1000, 32'h0);
        send_request(REQ_QUERY, 27'd999, 32'h0);
        send_request(REQ_QUERY, 27'd3000, 32'h0);
        send_request(REQ_RESERVED, 27'd5000, 32'h0);
        // Out-of-order key: the search may miss it
        send_request(REQ_APPEND, 27'd200, 32'hDEAD_BEEF);
        send_request(REQ_QUERY, 27'd200, 32'h0);
        send_request(REQ_QUERY, 27'd5000, 32'h0);
        send_request(REQ_CLEAR, 27'h7FF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_QUERY, 27'd1000, 32'h0);
        send_request(REQ_APPEND, KEY_TOP, 32'h0000_007B);
        send_request(REQ_QUERY, KEY_TOP, 32'h0);
        send_request(REQ_QUERY, KEY_TOP - 27'd1, 32'h0);
        send_request(REQ_CLEAR, 27'd0, 32'h0);
        wait_drained();
    endtask

    task automatic test_full_table();
        int step;
        int idx;
        logic [KEY_W-1:0] key;
        step = ((1 << KEY_W) - 1) / (TABLE_DEPTH + 8);
        key = KEY_W'($urandom_range(0, step));
        send_request(REQ_CLEAR, '0, '0);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_request(REQ_APPEND, key, $urandom());
            key = key + KEY_W'($urandom_range(1, step));
        end
        send_request(REQ_APPEND, key, $urandom());
        send_request(REQ_APPEND, 27'd0, 32'hFFFF_FFFF);
        send_request(REQ_QUERY, table_keys[0], '0);
        send_request(REQ_QUERY, table_keys[TABLE_DEPTH-1], '0);
        send_request(REQ_QUERY, table_keys[TABLE_DEPTH-1] + 27'd1, '0);
        send_request(REQ_QUERY, table_keys[TABLE_DEPTH/2 - 1], '0);
        for (int i = 0; i < 24; i++) begin
            idx = $urandom_range(0, TABLE_DEPTH - 1);
            key = table_keys[idx] + (($urandom_range(1) == 1) ? 27'd1 : 27'd0);
            send_request(REQ_QUERY, key, $urandom());
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int k;
        int step;
        int n_q;
        int pick;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] probe;
        logic [REQ_W-1:0] rt;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                send_request(REQ_CLEAR, KEY_W'($urandom()), $urandom());
                sent++;
            end
            if ($urandom_range(19) == 0) begin
                send_request(REQ_QUERY, KEY_W'($urandom()), $urandom());
                sent++;
            end
            k = ($urandom_range(9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 24);
            step = int'(KEY_TOP) / (k + 1);
            key = KEY_W'($urandom_range(0, step));
            for (int i = 0; i < k; i++) begin
                pick = $urandom_range(19);
                if (pick == 0) begin
                    // break the ascending order
                    send_request(REQ_APPEND, KEY_W'($urandom()), $urandom());
                end else if (pick == 1) begin
                    // hold the key so the next append repeats it
                    send_request(REQ_APPEND, key, $urandom());
                end else begin
                    send_request(REQ_APPEND, key, $urandom());
                    key = key + KEY_W'($urandom_range(1, step));
                end
            end
            sent += k;
            n_q = $urandom_range(1, k + 8);
            for (int j = 0; j < n_q; j++) begin
                pick = $urandom_range(99);
                if (table_count > 0) begin
                    probe = table_keys[$urandom_range(0, table_count - 1)];
                end else begin
                    probe = '0;
                end
                if (pick < 55) begin
                    key = probe;
                end else if (pick < 75) begin
                    key = ($urandom_range(1) == 1) ? probe + 27'd1 : probe - 27'd1;
                end else if (pick < 90) begin
                    key = KEY_W'($urandom_range(0, int'(KEY_TOP)));
                end else begin
                    key = KEY_W'($urandom());
                end
                rt = ($urandom_range(9) == 0) ? REQ_RESERVED : REQ_QUERY;
                send_request(rt, key, $urandom());
            end
            sent += n_q;
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        i_res_stall <= ($urandom_range(99) < res_stall_pct);
    end

    // Compare each taken result with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result status=%0d payload=%h",
                             o_status, o_payload_out);
                end
            end else begin
                oldest = pending_results.pop_front();
                if (o_status !== oldest.status || o_payload_out !== oldest.payload) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: expected status=%0d payload=%h, got status=%0d payload=%h",
                                 oldest.status, oldest.payload, o_status, o_payload_out);
                    end
                end
            end
        end
    end

    // End the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_res_valid && !i_res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        mismatches    = 0;
        quiet_cycles  = 0;
        table_count   = 0;
        send_idle_pct = 0;
        res_stall_pct = 0;
        i_rst_n      <= 1'b0;
        i_req_valid  <= 1'b0;
        i_req_type   <= REQ_QUERY;
        i_search_key <= '0;
        i_payload_in <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_directed_cases();
        test_full_table();
        test_random_traffic(50);
        set_idling(77, 0);
        test_random_traffic(50);
        set_idling(0, 77);
        test_random_traffic(50);
        set_idling(18, 18);
        test_random_traffic(50);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("ERROR: %0d results never arrived", pending_results.size());
        end
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
